### rtl/tdb_pkg.sv
package tdb_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;

    localparam logic [6:0] AMT_MAX = 7'd100;
    localparam logic [4:0] TANH_LAST = 5'd21;
    localparam logic [24:0] HALF_Q23 = 25'h80_0000;

    // tanh(k/4) in Q23, k = 0..21.
    localparam logic [22:0] TANH_Q23 [22] = '{
        23'd0, 23'd2054527, 23'd3876520, 23'd5328016, 23'd6388715, 23'd7115919,
        23'd7592934, 23'd7896830, 23'd8086849, 23'd8204278, 23'd8276321,
        23'd8320322, 23'd8347124, 23'd8363422, 23'd8373323, 23'd8379334,
        23'd8382982, 23'd8385195, 23'd8386538, 23'd8387352, 23'd8387846,
        23'd8388146
    };

    // 2^(j/25) in Q16, j = 0..24.
    localparam logic [16:0] POW2_Q16 [25] = '{
        17'd65536, 17'd67378, 17'd69273, 17'd71220, 17'd73223, 17'd75281,
        17'd77398, 17'd79573, 17'd81811, 17'd84111, 17'd86475, 17'd88906,
        17'd91406, 17'd93976, 17'd96618, 17'd99334, 17'd102127, 17'd104998,
        17'd107950, 17'd110985, 17'd114105, 17'd117313, 17'd120611,
        17'd124002, 17'd127488
    };

    // floor(2^56 / POW2_Q16[j]); shifting right by the octave gives 1/L in Q40.
    localparam logic [63:0] P56 = 64'h0100_0000_0000_0000;
    localparam logic [40:0] RECIP_Q56 [25] = '{
        41'(P56 / 64'd65536),  41'(P56 / 64'd67378),  41'(P56 / 64'd69273),
        41'(P56 / 64'd71220),  41'(P56 / 64'd73223),  41'(P56 / 64'd75281),
        41'(P56 / 64'd77398),  41'(P56 / 64'd79573),  41'(P56 / 64'd81811),
        41'(P56 / 64'd84111),  41'(P56 / 64'd86475),  41'(P56 / 64'd88906),
        41'(P56 / 64'd91406),  41'(P56 / 64'd93976),  41'(P56 / 64'd96618),
        41'(P56 / 64'd99334),  41'(P56 / 64'd102127), 41'(P56 / 64'd104998),
        41'(P56 / 64'd107950), 41'(P56 / 64'd110985), 41'(P56 / 64'd114105),
        41'(P56 / 64'd117313), 41'(P56 / 64'd120611), 41'(P56 / 64'd124002),
        41'(P56 / 64'd127488)
    };

    typedef struct packed {
        logic bypass;
        logic neg;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [6:0]  amt;
        logic [4:0]  ip;
        logic [16:0] p;
        logic [36:0] recip;
    } t_cfg;

    function automatic logic [22:0] tanh_q23(input logic [4:0] idx);
        tanh_q23 = (idx <= TANH_LAST) ? TANH_Q23[idx] : TANH_Q23[TANH_LAST];
    endfunction

    function automatic logic [16:0] pow2_q16(input logic [4:0] j);
        pow2_q16 = (j <= 5'd24) ? POW2_Q16[j] : POW2_Q16[0];
    endfunction

    function automatic logic [40:0] recip_q56(input logic [4:0] j);
        recip_q56 = (j <= 5'd24) ? RECIP_Q56[j] : RECIP_Q56[0];
    endfunction

endpackage

### rtl/tdb_in_if.sv
interface tdb_in_if #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

### rtl/tdb_out_if.sv
interface tdb_out_if #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

### rtl/tdb_cfg_if.sv
interface tdb_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] intensity;

    modport source (output valid, output intensity, input ready);
    modport sink (input valid, input intensity, output ready);
endinterface

### rtl/tdb_front.sv
module tdb_front #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_hold,
    input  tdb_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_ready,
    input  tdb_pkg::t_qstat        i_qstat,
    output logic                   o_push,
    output tdb_pkg::t_ctl          o_ctl,
    output logic [SAMPLE_BITS-1:0] o_mag
);

    logic                   r_fv;
    tdb_pkg::t_ctl          r_ctl;
    logic [SAMPLE_BITS-1:0] r_mag;
    tdb_pkg::t_ctl          n_ctl;
    logic [SAMPLE_BITS-1:0] n_mag;
    logic                   w_acc;

    assign o_ready = !i_hold && (!r_fv || !i_qstat.full);
    assign w_acc   = i_valid && o_ready;
    assign o_push  = r_fv && !i_qstat.full;
    assign o_ctl   = r_ctl;
    assign o_mag   = r_mag;

    // Classify: zero intensity passes the sample through untouched; split sign and magnitude.
    always_comb begin
        n_ctl.bypass = (i_cfg.amt == 7'd0);
        n_ctl.neg    = i_sample[SAMPLE_BITS-1];
        n_mag        = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

endmodule

### rtl/tdb_fifo.sv
module tdb_fifo #(
    parameter int WIDTH = tdb_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output tdb_pkg::t_qstat  o_stat
);

    localparam int PW = $clog2(tdb_pkg::QDEPTH);
    localparam int CW = PW + 1;

    logic [WIDTH-1:0] r_mem [tdb_pkg::QDEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(tdb_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/tdb_back.sv
module tdb_back #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tdb_pkg::t_cfg          i_cfg,
    input  tdb_pkg::t_qstat        i_qstat,
    input  logic [SAMPLE_BITS+1:0] i_data,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_sample,
    input  logic                   i_ready
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FRAC = SB - 1;
    localparam int SEG  = SB - 3;
    localparam int NST  = 8;
    // ceil(2^(SB+4) / 25): exact quotient by 25 for magnitudes up to 2^(SB-1).
    localparam logic [SB-1:0] RCP25 = SB'(((64'd1 << (SB + 4)) + 64'd24) / 64'd25);
    localparam logic [SB+18:0] RND_SEG = (SB + 19)'(1) << (SEG - 1);
    localparam logic [41:0]    RND_OUT = 42'(1) << (38 - FRAC);

    logic [NST-1:0]      r_v;
    tdb_pkg::t_ctl       r_ctl [NST-1];
    logic [SB-1:0]       r_mag [NST-1];
    logic                w_en;
    tdb_pkg::t_ctl       w_in_ctl;
    logic [SB-1:0]       w_in_mag;

    logic [2*SB-1:0]     r_p1,  n_p1;
    logic [SB+2:0]       r_qa,  n_qa;
    logic [11:0]         r_w,   n_w;
    logic [SB+1:0]       r_m,   n_m;
    logic [22:0]         r_t0,  n_t0;
    logic [SB+17:0]      r_dp,  n_dp;
    logic [41:0]         r_pr,  n_pr;
    logic [16:0]         r_q,   n_q;
    logic [40:0]         r_yp,  n_yp;
    logic [SB-1:0]       r_out, n_out;

    logic [SB-5:0]       w_qx;
    logic [SB-1:0]       w_qx25;
    logic [SB-1:0]       w_rxf;
    logic [4:0]          w_rx;
    logic [21:0]         w_w22;
    logic [6:0]          w_r2;
    logic [SB+2:0]       w_msum;
    logic [4:0]          w_idx;
    logic [SEG-1:0]      w_frac;
    logic [22:0]         w_lo;
    logic [22:0]         w_hi;
    logic [22:0]         w_dfull;
    logic [20:0]         w_diff;
    logic [SB+18:0]      w_dpr;
    logic [SB+18:0]      w_dps;
    logic [22:0]         w_th;
    logic [24:0]         w_u;
    logic [5:0]          w_sh;
    logic [41:0]         w_prs;
    logic [53:0]         w_yp54;
    logic [41:0]         w_yr;
    logic [SB+1:0]       w_yrs;
    logic [SB+1:0]       w_ym;

    // The whole pipeline moves together; it freezes only when the output is held.
    assign w_en     = !r_v[NST-1] || i_ready;
    assign o_pop    = w_en && !i_qstat.empty;
    assign w_in_ctl = i_data[SB+1:SB];
    assign w_in_mag = i_data[SB-1:0];
    assign o_valid  = r_v[NST-1];
    assign o_sample = r_out;

    always_comb begin
        // Stage 0: reciprocal product for the quotient by 25.
        n_p1 = {{SB{1'b0}}, w_in_mag} * {{SB{1'b0}}, RCP25};

        // Stage 1: |x| = 25*qx + rx, so |x|*a/25 = qx*a + rx*a/25.
        w_qx   = r_p1[2*SB-1:SB+4];
        w_qx25 = ({4'b0, w_qx} << 4) + ({4'b0, w_qx} << 3) + {4'b0, w_qx};
        w_rxf  = r_mag[0] - w_qx25;
        w_rx   = w_rxf[4:0];
        n_qa   = {7'b0, w_qx} * {{(SB - 4){1'b0}}, i_cfg.amt};
        n_w    = {7'b0, w_rx} * {5'b0, i_cfg.amt};

        // Stage 2: small quotient by 25 through 1311 / 2^15, then the driven magnitude.
        w_w22  = {10'b0, r_w} * 22'd1311;
        w_r2   = w_w22[21:15];
        w_msum = {3'b0, r_mag[1]} + r_qa + {{(SB - 4){1'b0}}, w_r2};
        n_m    = w_msum[SB+1:0];

        // Stage 3: table segment and interpolation product.
        w_idx   = r_m[SB+1:SB-3];
        w_frac  = r_m[SEG-1:0];
        w_lo    = tdb_pkg::tanh_q23(w_idx);
        w_hi    = tdb_pkg::tanh_q23(w_idx + 5'd1);
        w_dfull = w_hi - w_lo;
        if (w_idx >= tdb_pkg::TANH_LAST) begin
            n_t0   = tdb_pkg::TANH_Q23[tdb_pkg::TANH_LAST];
            w_diff = '0;
        end else begin
            n_t0   = w_lo;
            w_diff = w_dfull[20:0];
        end
        n_dp = {{(SB - 3){1'b0}}, w_diff} * {21'b0, w_frac};

        // Stage 4: rounded tanh, mapped to 0..2 in Q23, times the level mantissa.
        w_dpr = {1'b0, r_dp} + RND_SEG;
        w_dps = w_dpr >> SEG;
        w_th  = r_t0 + w_dps[22:0];
        w_u   = r_ctl[3].neg ? (tdb_pkg::HALF_Q23 - {2'b0, w_th})
                             : (tdb_pkg::HALF_Q23 + {2'b0, w_th});
        n_pr  = {17'b0, w_u} * {25'b0, i_cfg.p};

        // Stage 5: the octave of L becomes the shift; q is the level index.
        w_sh  = 6'd40 - {1'b0, i_cfg.ip};
        w_prs = r_pr >> w_sh;
        n_q   = w_prs[16:0];

        // Stage 6: scale the level index back by 1/L.
        w_yp54 = {37'b0, r_q} * {17'b0, i_cfg.recip};
        n_yp   = w_yp54[40:0];

        // Stage 7: round, recenter and saturate plus full scale, or restore a bypassed sample.
        w_yr  = ({1'b0, r_yp} + RND_OUT) >> (39 - FRAC);
        w_yrs = w_yr[SB+1:0];
        w_ym  = w_yrs - ((SB + 2)'(1) << FRAC);
        if (r_ctl[6].bypass) begin
            n_out = r_ctl[6].neg ? (~r_mag[6] + 1'b1) : r_mag[6];
        end else if (|w_yrs[SB+1:SB]) begin
            n_out = {1'b0, {(SB - 1){1'b1}}};
        end else begin
            n_out = w_ym[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[0] <= w_in_ctl;
            r_mag[0] <= w_in_mag;
            for (int k = 1; k < NST - 1; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_mag[k] <= r_mag[k-1];
            end
            r_p1  <= n_p1;
            r_qa  <= n_qa;
            r_w   <= n_w;
            r_m   <= n_m;
            r_t0  <= n_t0;
            r_dp  <= n_dp;
            r_pr  <= n_pr;
            r_q   <= n_q;
            r_yp  <= n_yp;
            r_out <= n_out;
        end
    end

endmodule

### rtl/tanh_drive_bitcrusher.sv
// Tanh drive and bit crusher for a stream of signed audio samples.
// Samples arrive on i_in (valid/ready, sample_in, full scale plus or minus one)
// and leave on o_out (valid/ready, sample_out) in the same order, one result per
// request. The intensity register is written through i_cfg (valid/ready); values
// above one hundred act as one hundred, and zero passes samples unchanged.
// A write stores the setting; the level count and its reciprocal follow in the
// next cycle, while i_in.ready stays low. Write it only while no sample is in
// flight. An accepted request passes the front register, the queue and the
// multiplier pipeline, ending in the output register, before o_out.valid rises.
// Throughput is one sample per cycle unless the output is held or a write
// settles, set by the back pipeline, whose shift and output stages hold no multiplier.
// When o_out.valid is high and o_out.ready low, the output register holds its
// sample and the whole back pipeline freezes; the front keeps filling a four-entry
// queue and deasserts i_in.ready only once the queue is full and its own register
// is occupied. During reset and in the cycle after it no request is taken on
// either channel, the pipeline is emptied and intensity returns to zero (bypass).
module tanh_drive_bitcrusher #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    tdb_in_if.sink   i_in,
    tdb_out_if.source o_out,
    tdb_cfg_if.sink  i_cfg
);

    // Exponent of the level count in hundredths of an octave: e = 1600 - 12a.
    localparam logic [10:0] E_BASE  = 11'd1600;
    localparam logic [10:0] E_STEP  = 11'd12;
    localparam logic [21:0] RCP100  = 22'd1311;
    localparam logic [10:0] HUNDRED = 11'd100;

    logic [6:0]        r_amt,   n_amt;
    logic [4:0]        r_ip,    n_ip;
    logic [4:0]        r_j,     n_j;
    logic [16:0]       r_p;
    logic [36:0]       r_recip;
    logic              r_upd;
    logic              r_cfg_rdy;
    logic [10:0]       w_e;
    logic [21:0]       w_e_m;
    logic [10:0]       w_rem;
    logic [40:0]       w_rq;
    logic              w_cfg_we;
    tdb_pkg::t_cfg     w_cfg;

    logic                   w_push;
    tdb_pkg::t_ctl          w_f_ctl;
    logic [SAMPLE_BITS-1:0] w_f_mag;
    logic [SAMPLE_BITS+1:0] w_q_data;
    logic                   w_pop;
    tdb_pkg::t_qstat        w_qstat;
    logic                   w_out_valid;
    logic [SAMPLE_BITS-1:0] w_out_sample;

    assign i_cfg.ready = r_cfg_rdy;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;

    // The octave ip = e / 100 comes from a reciprocal multiply that is exact for
    // e up to 1600; the remainder over four picks the fractional power of two.
    always_comb begin
        n_amt = (i_cfg.intensity > tdb_pkg::AMT_MAX) ? tdb_pkg::AMT_MAX : i_cfg.intensity;
        w_e   = E_BASE - ({4'b0, n_amt} * E_STEP);
        w_e_m = {11'b0, w_e} * RCP100;
        n_ip  = w_e_m[21:17];
        w_rem = w_e - ({6'b0, n_ip} * HUNDRED);
        n_j   = w_rem[6:2];
        w_rq  = tdb_pkg::recip_q56(r_j) >> r_ip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amt     <= '0;
            r_ip      <= 5'd16;
            r_j       <= '0;
            r_p       <= tdb_pkg::POW2_Q16[0];
            r_recip   <= 37'(tdb_pkg::RECIP_Q56[0] >> 16);
            r_upd     <= 1'b1;
            r_cfg_rdy <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                r_amt <= n_amt;
                r_ip  <= n_ip;
                r_j   <= n_j;
            end
            // The level mantissa and reciprocal follow the stored octave in the next cycle.
            r_p       <= tdb_pkg::pow2_q16(r_j);
            r_recip   <= w_rq[36:0];
            r_upd     <= w_cfg_we;
            r_cfg_rdy <= 1'b1;
        end
    end

    assign w_cfg.amt   = r_amt;
    assign w_cfg.ip    = r_ip;
    assign w_cfg.p     = r_p;
    assign w_cfg.recip = r_recip;

    tdb_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hold   (r_upd),
        .i_cfg    (w_cfg),
        .i_valid  (i_in.valid),
        .i_sample (i_in.sample_in),
        .o_ready  (i_in.ready),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_ctl    (w_f_ctl),
        .o_mag    (w_f_mag)
    );

    tdb_fifo #(
        .WIDTH(SAMPLE_BITS + 2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctl, w_f_mag}),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_qstat)
    );

    tdb_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_qstat  (w_qstat),
        .i_data   (w_q_data),
        .o_pop    (w_pop),
        .o_valid  (w_out_valid),
        .o_sample (w_out_sample),
        .i_ready  (o_out.ready)
    );

    assign o_out.valid      = w_out_valid;
    assign o_out.sample_out = w_out_sample;

    // The front must never push into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue push while full");

    // A register write blocks new samples while the derived values settle.
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_we |=> !i_in.ready)
        else $error("sample taken while configuration settles");

    // Any active intensity gives an octave of 4..15 and a valid mantissa index.
    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_amt != 7'd0) |-> (r_ip >= 5'd4 && r_ip <= 5'd15 && r_j <= 5'd24))
        else $error("derived level count out of range");

    // The pop side never takes from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue pop while empty");

endmodule

### verif/tb_tanh_drive_bitcrusher.sv
`timescale 1ns / 100ps

module tb_tanh_drive_bitcrusher;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    // Each tanh table segment spans a quarter of full scale.
    localparam int SEG_BITS = FRAC_BITS - 2;

    // A phase selects one intensity and then streams a batch of samples.
    localparam int PHASES = 14;
    localparam int ITEMS_PER_PHASE = 100;
    // Extra wait once idle, a comfortable margin over the pipeline depth.
    localparam int SETTLE_CYCLES = 20;
    // Length of the one long output stall that backs the block up.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any accepted request before the run is abandoned.
    // This must exceed the long output stall above.
    localparam int WATCHDOG_LIMIT = 2000;

    // Settings written first, in order: bypass, both ends of the range, two codes
    // above one hundred that must act as one hundred, and a mid setting.
    localparam logic [6:0] FIXED_LEVELS [6] = '{
        7'd0, 7'd100, 7'd1, 7'd127, 7'd101, 7'd50
    };

    // Directed samples: both full-scale limits, zero, the smallest steps on
    // either side, a table knot and two values deep in the soft clip.
    localparam logic [SAMPLE_BITS-1:0] EDGE_SAMPLES [8] = '{
        24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF,
        24'h000001, 24'h200000, 24'h333333, 24'hC00000
    };

    logic i_clk;
    logic i_rst_n;

    tdb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    tdb_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();
    tdb_cfg_if cfg_if ();

    tanh_drive_bitcrusher #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // Samples waiting to be offered, and predicted outputs waiting to be seen.
    logic [SAMPLE_BITS-1:0] dry_samples [$];
    logic [SAMPLE_BITS-1:0] crushed_q [$];
    int unsigned mismatch_count;

    // Predictor copy of the configuration and the values derived from it.
    int unsigned drive_amt;
    longint unsigned lvl_q16;
    longint unsigned inv_lvl_q40;

    // Pacing state of the sender and the receiver. A "calm" stretch has no
    // idle cycles at all; otherwise every item draws a random wait.
    int unsigned src_wait, src_run;
    bit src_calm;
    int unsigned snk_wait, snk_run, snk_hold;
    bit snk_calm, hold_taken;
    bit pressure_req;

    int unsigned quiet_cycles;

    always #1 i_clk = ~i_clk;

    // Clamp the setting, then rebuild the level count L = 2^(16 - 12a/100)
    // in Q16 and its reciprocal in Q40, just as a register write does.
    function automatic void load_intensity(input logic [6:0] val);
        int unsigned e;
        longint unsigned frac_q16;
        drive_amt = (val > tdb_pkg::AMT_MAX) ? tdb_pkg::AMT_MAX : val;
        e = 1600 - 12 * drive_amt;
        frac_q16 = tdb_pkg::POW2_Q16[(e % 100) / 4];
        lvl_q16 = frac_q16 << (e / 100);
        inv_lvl_q40 = (64'd1 << 56) / lvl_q16;
    endfunction

    // Drive, soft clip, quantize to L levels and map back to Q0.23.
    function automatic logic [SAMPLE_BITS-1:0] crush_sample(
        input logic [SAMPLE_BITS-1:0] raw
    );
        longint x, v, t, y;
        longint unsigned m, seg, frac, diff, th, u24, q, yq;
        int k;
        if (drive_amt == 0) begin
            return raw;
        end
        x = $signed(raw);
        // Signed division truncates toward zero, keeping |v| at most 5.0.
        v = (x * longint'(25 + drive_amt)) / 25;
        m = (v < 0) ? -v : v;
        seg = m >> SEG_BITS;
        if (seg >= tdb_pkg::TANH_LAST) begin
            th = tdb_pkg::TANH_Q23[tdb_pkg::TANH_LAST];
        end else begin
            k = int'(seg);
            frac = m & ((64'd1 << SEG_BITS) - 1);
            diff = longint'(tdb_pkg::TANH_Q23[k + 1]) - longint'(tdb_pkg::TANH_Q23[k]);
            th = longint'(tdb_pkg::TANH_Q23[k]) +
                 ((diff * frac + (64'd1 << (SEG_BITS - 1))) >> SEG_BITS);
        end
        // tanh is odd, so negative drive mirrors the table.
        t = (v < 0) ? -longint'(th) : longint'(th);
        u24 = t + (longint'(1) << FRAC_BITS);
        q = (u24 * lvl_q16) >> 40;
        yq = (q * inv_lvl_q40 + (64'd1 << (38 - FRAC_BITS))) >> (39 - FRAC_BITS);
        y = longint'(yq) - (longint'(1) << FRAC_BITS);
        // A result of +1.0 cannot be represented and saturates.
        if (y > (longint'(1) << FRAC_BITS) - 1) begin
            y = (longint'(1) << FRAC_BITS) - 1;
        end
        if (y < -(longint'(1) << FRAC_BITS)) begin
            y = -(longint'(1) << FRAC_BITS);
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    // Random samples: full range, quiet signals, near full scale, mid level.
    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        logic [SAMPLE_BITS-1:0] mag;
        case ($urandom_range(0, 3))
            0: begin
                return SAMPLE_BITS'($urandom);
            end
            1: begin
                return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
            end
            2: begin
                mag = SAMPLE_BITS'(24'h7FFFFF - $urandom_range(0, 65535));
            end
            default: begin
                mag = SAMPLE_BITS'($urandom_range(0, 24'h400000));
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Sender. A new sample is offered once the previous request has been
    // taken and the drawn wait has run out; valid is never dropped while a
    // request is pending.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_wait = 0;
            src_run = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (src_wait != 0) begin
                in_if.valid <= 1'b0;
                src_wait = src_wait - 1;
            end else if (dry_samples.size() != 0) begin
                in_if.valid <= 1'b1;
                in_if.sample_in <= dry_samples.pop_front();
                if (src_run == 0) begin
                    src_run = $urandom_range(8, 64);
                    src_calm = ($urandom_range(0, 3) == 0);
                end
                src_run = src_run - 1;
                src_wait = draw_wait(src_calm);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver. After every result it draws a stall. Once, on request, it
    // holds ready low for a long stretch that it counts itself, while the
    // sender keeps offering, so the internal queue fills and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            snk_wait = 0;
            snk_run = 0;
            snk_hold = 0;
        end else begin
            if (pressure_req && !hold_taken) begin
                hold_taken = 1'b1;
                snk_hold = HOLD_CYCLES;
            end
            if (out_if.valid && out_if.ready) begin
                if (snk_run == 0) begin
                    snk_run = $urandom_range(8, 64);
                    snk_calm = ($urandom_range(0, 3) == 0);
                end
                snk_run = snk_run - 1;
                snk_wait = draw_wait(snk_calm);
            end
            if (snk_hold != 0) begin
                snk_hold = snk_hold - 1;
                out_if.ready <= 1'b0;
            end else if (snk_wait != 0) begin
                snk_wait = snk_wait - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Monitor. All channels are sampled at the rising edge, before any of
    // this edge's updates land, so the values seen are the ones the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                load_intensity(cfg_if.intensity);
            end
            if (in_if.valid && in_if.ready) begin
                crushed_q = {crushed_q, crush_sample(in_if.sample_in)};
            end
            if (out_if.valid && out_if.ready) begin
                if (crushed_q.size() == 0) begin
                    $error("sample_out: expected nothing, actual %0d",
                           $signed(out_if.sample_out));
                    mismatch_count = mismatch_count + 1;
                end else if (out_if.sample_out !== crushed_q[0]) begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(crushed_q[0]), $signed(out_if.sample_out));
                    mismatch_count = mismatch_count + 1;
                    void'(crushed_q.pop_front());
                end else begin
                    void'(crushed_q.pop_front());
                end
            end
        end
    end

    // Watchdog: any accepted request on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tanh_drive_bitcrusher: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One intensity write; returns at the edge where the request is taken.
    task automatic write_intensity(input logic [6:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.intensity <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // The block is idle once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        while (dry_samples.size() != 0 || in_if.valid || crushed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [6:0] level;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.sample_in = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.intensity = '0;
        pressure_req = 1'b0;
        hold_taken = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        // The block comes out of reset in bypass.
        load_intensity(7'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each phase changes the intensity only while the block is empty,
        // then streams a batch of samples under random pacing.
        for (int ph = 0; ph < PHASES; ph++) begin
            level = (ph < 6) ? FIXED_LEVELS[ph] : 7'($urandom_range(0, 127));
            write_intensity(level);
            if (ph < 3) begin
                foreach (EDGE_SAMPLES[k]) begin
                    dry_samples = {dry_samples, EDGE_SAMPLES[k]};
                end
            end
            // The long output stall lands in a phase with the effect at maximum.
            if (ph == 4) begin
                pressure_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) dry_samples = {dry_samples, draw_sample()};
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("tanh_drive_bitcrusher: match");
        end else begin
            $display("tanh_drive_bitcrusher: mismatch");
        end
        $finish;
    end

endmodule
